FILE: rtl/csvg_pkg.sv
// ============================================================================
// csvg_pkg - shared types and constants of the cube sphere vertex generator
// Field widths, face codes, lane numbering and the pipeline tag.
// ============================================================================
package csvg_pkg;

    localparam int unsigned MAX_LEVEL_DEF = 8;
    localparam int unsigned FRAC_BITS_DEF = 14;

    localparam int unsigned LVL_W   = 4;
    localparam int unsigned IDX_W   = 8;   // row / column index
    localparam int unsigned K_W     = 8;   // grid size K, up to 128
    localparam int unsigned MAG_W   = 8;   // |component| scaled by K, up to 128
    localparam int unsigned SQ_W    = 15;  // square of a magnitude
    localparam int unsigned S_W     = 16;  // sum of three squares
    localparam int unsigned FACE_W  = 3;
    localparam int unsigned VEC_W   = 16;

    localparam logic [LVL_W-1:0] LVL_SUBST = 4'd4;  // stands in for level 0

    localparam int unsigned N_LANES = 3;
    localparam int unsigned LANE_X  = 0;
    localparam int unsigned LANE_Y  = 1;
    localparam int unsigned LANE_Z  = 2;

    // input pacing: transactions are spaced so that their six results do not overlap
    localparam int unsigned ITEM_CYCLES = 6;
    localparam int unsigned GAP_W       = 3;

    typedef logic [FACE_W-1:0]        t_face;
    typedef logic signed [VEC_W-1:0]  t_vec;

    localparam t_face FACE_0 = 3'd0;
    localparam t_face FACE_1 = 3'd1;
    localparam t_face FACE_2 = 3'd2;
    localparam t_face FACE_3 = 3'd3;
    localparam t_face FACE_4 = 3'd4;
    localparam t_face FACE_5 = 3'd5;

    localparam logic [VEC_W-2:0] MAG_SAT = 15'h7FFF;

    // control that travels alongside each item in the pipeline
    typedef struct packed {
        logic vld;
        logic bad;
        logic neg_y;
        logic neg_z;
    } t_tag;

endpackage

FILE: rtl/cube_sphere_vertex_gen.sv
// ============================================================================
// cube_sphere_vertex_gen - unit sphere vertices from a cube face grid point
// Pipeline: the front stages, the square root search and the face register;
//   the six vertices of a grid point then follow on consecutive cycles.
// Pacing: busy spaces transactions, set by the single result port that carries
//   six vertices per grid point; the pipeline itself takes one a cycle.
// Reset (synchronous, active low) empties the pipeline and sets level to 4.
// ============================================================================
module cube_sphere_vertex_gen #(
    parameter int unsigned MAX_LEVEL = csvg_pkg::MAX_LEVEL_DEF,
    parameter int unsigned FRAC_BITS = csvg_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  logic [csvg_pkg::IDX_W-1:0]      i_row_index,
    input  logic [csvg_pkg::IDX_W-1:0]      i_col_index,
    // level register write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [csvg_pkg::LVL_W-1:0]      i_cfg_data,
    // result strobe and fields
    output logic                            o_result_valid,
    output logic [csvg_pkg::FACE_W-1:0]     o_face,
    output logic signed [csvg_pkg::VEC_W-1:0] o_vx,
    output logic signed [csvg_pkg::VEC_W-1:0] o_vy,
    output logic signed [csvg_pkg::VEC_W-1:0] o_vz,
    output logic                            o_bad_index,
    output logic                            o_last
);
    import csvg_pkg::*;

    // Datapath widths of the square root search:
    //   q  : result magnitude, up to 2^FRAC_BITS
    //   P,R: (2q-1)^2 * S and 4*c^2*2^(2*FRAC_BITS), unsigned
    //   W  : (2q-1) * S, signed (starts at -S)
    localparam int unsigned QW = FRAC_BITS + 1;
    localparam int unsigned TW = 2 * FRAC_BITS + 20;
    localparam int unsigned WW = FRAC_BITS + 19;
    localparam int unsigned NSTEP = FRAC_BITS + 1;

    logic                 accept;
    logic [LVL_W-1:0]     r_level;
    logic [GAP_W-1:0]     r_gap;

    t_tag                          front_tag;
    logic [S_W-1:0]                front_s;
    logic [N_LANES-1:0][SQ_W-1:0]  front_sq;

    // one entry per step boundary: entry 0 feeds the first step, entry NSTEP
    // holds the finished magnitudes
    t_tag                          tag_pipe [NSTEP+1];
    logic [S_W-1:0]                s_pipe   [NSTEP+1];
    logic [N_LANES-1:0][TW-1:0]    r_pipe   [NSTEP+1];
    logic [N_LANES-1:0][TW-1:0]    p_pipe   [NSTEP+1];
    logic [N_LANES-1:0][WW-1:0]    w_pipe   [NSTEP+1];
    logic [N_LANES-1:0][QW-1:0]    q_pipe   [NSTEP+1];

    // A transaction is taken when start is high and the pacing counter has run
    // out; the counter spaces transactions so the face sequencer never overlaps.
    assign accept = start && !busy;
    assign busy   = (r_gap != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (accept) begin
            r_gap <= GAP_W'(ITEM_CYCLES - 1);
        end else if (busy) begin
            r_gap <= r_gap - GAP_W'(1);
        end
    end

    // Level reg: always ready; user writes only while block is idle, unchecked.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LVL_SUBST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_level <= i_cfg_data;
        end
    end

    // Stages 1 to 3: grid size, signed components, squares and their sum.
    csvg_front #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (accept),
        .i_level (r_level),
        .i_row   (i_row_index),
        .i_col   (i_col_index),
        .o_tag   (front_tag),
        .o_s     (front_s),
        .o_sq    (front_sq)
    );

    // Seed the search: q = 0, so 2q-1 = -1, P = S and W = -S.
    assign tag_pipe[0] = front_tag;
    assign s_pipe[0]   = front_s;

    for (genvar l = 0; l < N_LANES; l++) begin : g_seed
        assign r_pipe[0][l] = TW'(front_sq[l]) << (2 * FRAC_BITS + 2);
        assign p_pipe[0][l] = TW'(front_s);
        assign w_pipe[0][l] = WW'(-$signed({{(WW-S_W){1'b0}}, front_s}));
        assign q_pipe[0][l] = '0;
    end

    // One stage per result bit, most significant bit first.
    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        csvg_root_step #(
            .FRAC_BITS (FRAC_BITS),
            .BIT       (FRAC_BITS - i)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (tag_pipe[i]),
            .i_s     (s_pipe[i]),
            .i_r     (r_pipe[i]),
            .i_p     (p_pipe[i]),
            .i_w     (w_pipe[i]),
            .i_q     (q_pipe[i]),
            .o_tag   (tag_pipe[i+1]),
            .o_s     (s_pipe[i+1]),
            .o_r     (r_pipe[i+1]),
            .o_p     (p_pipe[i+1]),
            .o_w     (w_pipe[i+1]),
            .o_q     (q_pipe[i+1])
        );
    end

    // Sign, saturate, zero on a bad index, then walk the six faces.
    csvg_face_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_face_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (tag_pipe[NSTEP]),
        .i_q     (q_pipe[NSTEP]),
        .o_valid (o_result_valid),
        .o_face  (o_face),
        .o_vx    (o_vx),
        .o_vy    (o_vy),
        .o_vz    (o_vz),
        .o_bad   (o_bad_index),
        .o_last  (o_last)
    );

endmodule

FILE: rtl/csvg_front.sv
// ============================================================================
// csvg_front - grid decode and sum of squares
// Three stages: grid size and range check, signed components, squares.
// ============================================================================
module csvg_front #(
    parameter int unsigned MAX_LEVEL = csvg_pkg::MAX_LEVEL_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_vld,
    input  logic [csvg_pkg::LVL_W-1:0]                          i_level,
    input  logic [csvg_pkg::IDX_W-1:0]                          i_row,
    input  logic [csvg_pkg::IDX_W-1:0]                          i_col,
    output csvg_pkg::t_tag                                      o_tag,
    output logic [csvg_pkg::S_W-1:0]                            o_s,
    output logic [csvg_pkg::N_LANES-1:0][csvg_pkg::SQ_W-1:0]    o_sq
);
    import csvg_pkg::*;

    localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_LEVEL);

    logic [LVL_W-1:0] lvl_sub;
    logic [LVL_W-1:0] lvl_eff;
    logic [K_W-1:0]   k;
    logic             bad;

    logic             r1_vld;
    logic             r1_bad;
    logic [K_W-1:0]   r1_k;
    logic [IDX_W-1:0] r1_row;
    logic [IDX_W-1:0] r1_col;

    logic signed [IDX_W+1:0] cy;
    logic signed [IDX_W+1:0] cz;
    logic signed [IDX_W+1:0] ay;
    logic signed [IDX_W+1:0] az;

    logic                               r2_vld;
    logic                               r2_bad;
    logic                               r2_neg_y;
    logic                               r2_neg_z;
    logic [N_LANES-1:0][MAG_W-1:0]      r2_mag;

    logic [N_LANES-1:0][SQ_W-1:0]       sq;
    logic [S_W-1:0]                     s_sum;

    t_tag                               r3_tag;
    logic [S_W-1:0]                     r3_s;
    logic [N_LANES-1:0][SQ_W-1:0]       r3_sq;

    // stage 1: effective level, grid size K, range check
    always_comb begin
        lvl_sub = (i_level == '0) ? LVL_SUBST : i_level;
        lvl_eff = (lvl_sub > MAX_LVL) ? MAX_LVL : lvl_sub;
        k       = K_W'(1) << (lvl_eff - LVL_W'(1));
        bad     = (i_row > k) || (i_col > k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_bad <= bad;
        r1_k   <= k;
        r1_row <= i_row;
        r1_col <= i_col;
    end

    // stage 2: components scaled by K, split into sign and magnitude
    always_comb begin
        cy = $signed({1'b0, r1_col, 1'b0}) - $signed({2'b00, r1_k});
        cz = $signed({1'b0, r1_row, 1'b0}) - $signed({2'b00, r1_k});
        ay = (cy < 0) ? -cy : cy;
        az = (cz < 0) ? -cz : cz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_bad         <= r1_bad;
        r2_neg_y       <= cy[IDX_W+1];
        r2_neg_z       <= cz[IDX_W+1];
        r2_mag[LANE_X] <= r1_k;
        r2_mag[LANE_Y] <= ay[MAG_W-1:0];
        r2_mag[LANE_Z] <= az[MAG_W-1:0];
    end

    // stage 3: squares and their sum
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            sq[l] = SQ_W'(r2_mag[l]) * SQ_W'(r2_mag[l]);
        end
        s_sum = S_W'(sq[LANE_X]) + S_W'(sq[LANE_Y]) + S_W'(sq[LANE_Z]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_tag <= '0;
        end else begin
            r3_tag <= '{vld: r2_vld, bad: r2_bad, neg_y: r2_neg_y, neg_z: r2_neg_z};
        end
    end

    always_ff @(posedge i_clk) begin
        r3_s  <= s_sum;
        r3_sq <= sq;
    end

    assign o_tag = r3_tag;
    assign o_s   = r3_s;
    assign o_sq  = r3_sq;

endmodule

FILE: rtl/csvg_root_step.sv
// ============================================================================
// csvg_root_step - one bit of the rounded inverse square root search
// Decides bit BIT of q for all three lanes with shift and add updates only.
// ============================================================================
module csvg_root_step #(
    parameter int unsigned FRAC_BITS = csvg_pkg::FRAC_BITS_DEF,
    parameter int unsigned BIT       = 0
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  csvg_pkg::t_tag                              i_tag,
    input  logic [csvg_pkg::S_W-1:0]                    i_s,
    input  logic [csvg_pkg::N_LANES-1:0][2*FRAC_BITS+19:0] i_r,
    input  logic [csvg_pkg::N_LANES-1:0][2*FRAC_BITS+19:0] i_p,
    input  logic [csvg_pkg::N_LANES-1:0][FRAC_BITS+18:0]   i_w,
    input  logic [csvg_pkg::N_LANES-1:0][FRAC_BITS:0]      i_q,
    output csvg_pkg::t_tag                              o_tag,
    output logic [csvg_pkg::S_W-1:0]                    o_s,
    output logic [csvg_pkg::N_LANES-1:0][2*FRAC_BITS+19:0] o_r,
    output logic [csvg_pkg::N_LANES-1:0][2*FRAC_BITS+19:0] o_p,
    output logic [csvg_pkg::N_LANES-1:0][FRAC_BITS+18:0]   o_w,
    output logic [csvg_pkg::N_LANES-1:0][FRAC_BITS:0]      o_q
);
    import csvg_pkg::*;

    localparam int unsigned QW = FRAC_BITS + 1;
    localparam int unsigned TW = 2 * FRAC_BITS + 20;
    localparam int unsigned WW = FRAC_BITS + 19;
    localparam int unsigned XW = 2 * FRAC_BITS + 22;

    // P = (2q-1)^2 * S and W = (2q-1) * S; trial adds d = 2^(BIT+1) to 2q-1:
    // T = P + 2*W*d + d^2*S
    logic signed [XW-1:0] s_x;
    logic signed [WW-1:0] s_w;
    logic [N_LANES-1:0][TW-1:0] n_p;
    logic [N_LANES-1:0][WW-1:0] n_w;
    logic [N_LANES-1:0][QW-1:0] n_q;

    t_tag                       r_tag;
    logic [S_W-1:0]             r_s;
    logic [N_LANES-1:0][TW-1:0] r_r;
    logic [N_LANES-1:0][TW-1:0] r_p;
    logic [N_LANES-1:0][WW-1:0] r_w;
    logic [N_LANES-1:0][QW-1:0] r_q;

    assign s_x = $signed({{(XW-S_W){1'b0}}, i_s});
    assign s_w = $signed({{(WW-S_W){1'b0}}, i_s});

    for (genvar l = 0; l < N_LANES; l++) begin : g_lane
        logic signed [XW-1:0] p_x;
        logic signed [XW-1:0] w_x;
        logic signed [XW-1:0] r_x;
        logic signed [XW-1:0] t_x;
        logic                 take;

        assign p_x  = $signed({{(XW-TW){1'b0}}, i_p[l]});
        assign w_x  = $signed({{(XW-WW){i_w[l][WW-1]}}, i_w[l]});
        assign r_x  = $signed({{(XW-TW){1'b0}}, i_r[l]});
        assign t_x  = p_x + (w_x <<< (BIT + 2)) + (s_x <<< (2 * BIT + 2));
        // q may not pass 2^FRAC_BITS
        assign take = !i_q[l][QW-1] && (t_x <= r_x);

        assign n_p[l] = take ? t_x[TW-1:0] : i_p[l];
        assign n_w[l] = take ? WW'($signed(i_w[l]) + (s_w <<< (BIT + 1))) : i_w[l];
        assign n_q[l] = take ? (i_q[l] | (QW'(1) << BIT)) : i_q[l];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= i_s;
        r_r <= i_r;
        r_p <= n_p;
        r_w <= n_w;
        r_q <= n_q;
    end

    assign o_tag = r_tag;
    assign o_s   = r_s;
    assign o_r   = r_r;
    assign o_p   = r_p;
    assign o_w   = r_w;
    assign o_q   = r_q;

endmodule

FILE: rtl/csvg_face_out.sv
// ============================================================================
// csvg_face_out - sign, saturate and emit the six cube face vertices
// Holds one normalized vector and steps through the faces, one per cycle.
// ============================================================================
module csvg_face_out #(
    parameter int unsigned FRAC_BITS = csvg_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  csvg_pkg::t_tag                              i_tag,
    input  logic [csvg_pkg::N_LANES-1:0][FRAC_BITS:0]   i_q,
    output logic                                        o_valid,
    output csvg_pkg::t_face                             o_face,
    output csvg_pkg::t_vec                              o_vx,
    output csvg_pkg::t_vec                              o_vy,
    output csvg_pkg::t_vec                              o_vz,
    output logic                                        o_bad,
    output logic                                        o_last
);
    import csvg_pkg::*;

    localparam int unsigned QW = FRAC_BITS + 1;
    localparam int unsigned EW = (QW > VEC_W) ? QW : VEC_W;

    logic [N_LANES-1:0]    neg;
    t_vec                  vec [N_LANES];

    t_vec  r_x;
    t_vec  r_y;
    t_vec  r_z;
    logic  r_bad;
    logic  r_run;
    t_face r_face;

    assign neg[LANE_X] = 1'b0;
    assign neg[LANE_Y] = i_tag.neg_y;
    assign neg[LANE_Z] = i_tag.neg_z;

    for (genvar l = 0; l < N_LANES; l++) begin : g_lane
        logic [EW-1:0]      q_ext;
        logic [VEC_W-2:0]   mag;
        t_vec               pos;

        assign q_ext  = EW'(i_q[l]);
        assign mag    = (q_ext > EW'(MAG_SAT)) ? MAG_SAT : q_ext[VEC_W-2:0];
        assign pos    = $signed({1'b0, mag});
        assign vec[l] = i_tag.bad ? '0 : (neg[l] ? -pos : pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_face <= FACE_0;
        end else if (i_tag.vld) begin
            r_run  <= 1'b1;
            r_face <= FACE_0;
        end else if (r_run) begin
            if (r_face == FACE_5) begin
                r_run <= 1'b0;
            end
            r_face <= r_face + t_face'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tag.vld) begin
            r_x   <= vec[LANE_X];
            r_y   <= vec[LANE_Y];
            r_z   <= vec[LANE_Z];
            r_bad <= i_tag.bad;
        end
    end

    // axis swaps and sign flips per face
    always_comb begin
        case (r_face)
            FACE_0: begin
                o_vx = r_x;   o_vy = r_y;   o_vz = r_z;
            end
            FACE_1: begin
                o_vx = -r_x;  o_vy = -r_y;  o_vz = r_z;
            end
            FACE_2: begin
                o_vx = -r_y;  o_vy = r_x;   o_vz = r_z;
            end
            FACE_3: begin
                o_vx = r_y;   o_vy = -r_x;  o_vz = r_z;
            end
            FACE_4: begin
                o_vx = -r_z;  o_vy = r_y;   o_vz = r_x;
            end
            FACE_5: begin
                o_vx = r_z;   o_vy = r_y;   o_vz = -r_x;
            end
            default: begin
                o_vx = '0;    o_vy = '0;    o_vz = '0;
            end
        endcase
    end

    assign o_valid = r_run;
    assign o_face  = r_face;
    assign o_bad   = r_bad;
    assign o_last  = (r_face == FACE_5);

endmodule
